// ===== src/set_assoc_cache_lru_tag_model_assert.svh =====
// Assertion macros used by the checker file
`ifndef SET_ASSOC_CACHE_LRU_TAG_MODEL_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TAG_MODEL_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SACL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== src/sacl_pkg.sv =====
package sacl_pkg;
   localparam int MAX_SET_BITS_DEF = 8;
   localparam int MAX_WAYS_DEF     = 8;
   localparam int ADDR_W   = 64;
   localparam int CNT_W    = 32;
   localparam int STAMP_W  = 64;
   localparam int KIND_W   = 2;
   localparam int OUTC_W   = 2;
   localparam int WAYF_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

   localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
   localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
   localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_UPDATE,
      BK_CLEAR
   } back_state_type;

   // Classified access handed from front to back
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              is_last;
   } access_type;
endpackage

// ===== src/sacl_if.sv =====
interface sacl_req_if;
   logic                             valid;
   logic                             ready;
   logic [sacl_pkg::KIND_W-1:0]      kind;
   logic [sacl_pkg::ADDR_W-1:0]      address;
   modport source (output valid, kind, address, input ready);
   modport sink   (input valid, kind, address, output ready);
endinterface

interface sacl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sacl_pkg::OUTC_W-1:0]      outcome;
   logic [sacl_pkg::WAYF_W-1:0]      way_used;
   logic [sacl_pkg::CNT_W-1:0]       hits_so_far;
   logic [sacl_pkg::CNT_W-1:0]       misses_so_far;
   logic [sacl_pkg::CNT_W-1:0]       evictions_so_far;
   logic                             last;
   modport source (output valid, outcome, way_used, hits_so_far, misses_so_far,
                   evictions_so_far, last, input ready);
   modport sink   (input valid, outcome, way_used, hits_so_far, misses_so_far,
                   evictions_so_far, last, output ready);
endinterface

// ===== src/sacl_front.sv =====
// Front: takes items, splits a modify into two accesses, queues them
module sacl_front (
   input  logic                  clock,
   input  logic                  reset,
   sacl_req_if.sink              req,
   output logic                  q_valid,
   output sacl_pkg::access_type  q_data,
   input  logic                  q_pop
);
   localparam int DEPTH = 4;

   sacl_pkg::access_type fifo_ff [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       second_ff, second_in;
   logic       push;
   logic       is_mod;
   sacl_pkg::access_type push_data;

   assign is_mod  = (req.kind == sacl_pkg::KIND_MODIFY);
   // A modify holds the channel until its second access is queued
   assign req.ready = (cnt_ff < 3'(DEPTH)) && (!is_mod || second_ff);
   assign push    = req.valid && (cnt_ff < 3'(DEPTH));
   assign push_data.address = req.address;
   assign push_data.is_last = !is_mod || second_ff;

   assign q_valid = (cnt_ff != 3'd0);
   assign q_data  = fifo_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff + 2'(push);
      rd_in = rd_ff + 2'(q_pop);
      cnt_in = cnt_ff + 3'(push) - 3'(q_pop);
      second_in = second_ff;
      if (push && is_mod) second_in = !second_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0; second_ff <= 1'b0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in; second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ff] <= push_data;
   end
endmodule

// ===== src/sacl_back.sv =====
// Back: set read, way compare and LRU pick, then write back and result
module sacl_back #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  sacl_pkg::access_type  q_data,
   output logic                  q_pop,
   input  logic [3:0]            set_bits,
   input  logic [5:0]            offset_bits,
   input  logic [3:0]            ways_in_use,
   sacl_rsp_if.source            rsp
);
   localparam int SETS   = 1 << MAX_SET_BITS;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SI_W   = MAX_SET_BITS;
   localparam int TAG_W  = sacl_pkg::ADDR_W - 2;

   typedef struct packed {
      logic                          valid;
      logic [TAG_W-1:0]              tag;
      logic [sacl_pkg::STAMP_W-1:0]  stamp;
   } line_type;

   // One row per set, all ways side by side
   line_type mem [SETS][MAX_WAYS];
   line_type rdata_ff [MAX_WAYS];

   sacl_pkg::back_state_type st_ff, st_in;
   logic [SI_W-1:0]   idx_ff, idx_in, clr_ff, clr_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              last_ff, last_in;
   logic [sacl_pkg::STAMP_W-1:0] clk_ff, clk_in;
   logic [sacl_pkg::CNT_W-1:0]   hit_ff, hit_in, miss_ff, miss_in, evc_ff, evc_in;
   logic              out_v_ff, out_v_in;
   logic [sacl_pkg::OUTC_W-1:0] outc_ff, outc_in;
   logic [sacl_pkg::WAYF_W-1:0] wayo_ff, wayo_in;
   logic              out_last_ff, out_last_in;

   logic [3:0] s_eff;
   logic [5:0] b_eff;
   logic [4:0] e_eff;
   logic [6:0] sb;
   logic [SI_W-1:0]  idx_c;
   logic [TAG_W-1:0] tag_c;

   logic              hit, empty;
   logic [WAY_W-1:0]  hit_w, emp_w, lru_w, pick;
   logic [sacl_pkg::STAMP_W-1:0] best;
   logic              wr_en;
   logic [SI_W-1:0]   wr_idx;
   line_type          wr_line;
   logic [WAY_W-1:0]  wr_way;
   logic              wr_all;

   // Clamp the configuration to its legal range
   always_comb begin
      s_eff = set_bits;
      if (s_eff < 4'd1) s_eff = 4'd1;
      if (32'(s_eff) > MAX_SET_BITS) s_eff = 4'(MAX_SET_BITS);
      b_eff = (offset_bits == 6'd0) ? 6'd1 : offset_bits;
      e_eff = 5'(ways_in_use);
      if (e_eff < 5'd1) e_eff = 5'd1;
      if (32'(e_eff) > MAX_WAYS) e_eff = 5'(MAX_WAYS);
      sb = 7'(s_eff) + 7'(b_eff);
   end

   // Address split; tag is at most 62 bits since s and b are at least one
   always_comb begin
      logic [sacl_pkg::ADDR_W-1:0] sh;
      logic [sacl_pkg::ADDR_W-1:0] t;
      sh = q_data.address >> b_eff;
      idx_c = SI_W'(sh & ((64'd1 << s_eff) - 64'd1));
      t = (sb < 7'd64) ? (q_data.address >> sb) : '0;
      tag_c = t[TAG_W-1:0];
   end

   // Way search over the registered row
   always_comb begin
      hit = 1'b0; empty = 1'b0;
      hit_w = '0; emp_w = '0; lru_w = '0;
      best = rdata_ff[0].stamp;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (5'(w) < e_eff) begin
            if (rdata_ff[w].valid && rdata_ff[w].tag == tag_ff) begin
               hit = 1'b1; hit_w = WAY_W'(w);
            end
            if (!rdata_ff[w].valid) begin
               empty = 1'b1; emp_w = WAY_W'(w);
            end
         end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (5'(w) < e_eff && rdata_ff[w].stamp < best) begin
            best = rdata_ff[w].stamp; lru_w = WAY_W'(w);
         end
      end
      pick = hit ? hit_w : (empty ? emp_w : lru_w);
   end

   assign rsp.valid            = out_v_ff;
   assign rsp.outcome          = outc_ff;
   assign rsp.way_used         = wayo_ff;
   assign rsp.hits_so_far      = hit_ff;
   assign rsp.misses_so_far    = miss_ff;
   assign rsp.evictions_so_far = evc_ff;
   assign rsp.last             = out_last_ff;

   // Sequencer: clear sweep after reset, then read and update per access
   always_comb begin
      st_in = st_ff; idx_in = idx_ff; tag_in = tag_ff; last_in = last_ff;
      clr_in = clr_ff; clk_in = clk_ff;
      hit_in = hit_ff; miss_in = miss_ff; evc_in = evc_ff;
      out_v_in = out_v_ff && !rsp.ready;
      outc_in = outc_ff; wayo_in = wayo_ff; out_last_in = out_last_ff;
      q_pop = 1'b0;
      wr_en = 1'b0; wr_all = 1'b0; wr_idx = idx_ff; wr_way = pick;
      wr_line.valid = 1'b1; wr_line.tag = tag_ff; wr_line.stamp = clk_ff + 64'd1;
      case (st_ff)
         sacl_pkg::BK_CLEAR: begin
            wr_en = 1'b1; wr_all = 1'b1; wr_idx = clr_ff; wr_line = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SI_W'(SETS - 1)) st_in = sacl_pkg::BK_IDLE;
         end
         sacl_pkg::BK_IDLE: begin
            if (q_valid && !out_v_in) begin
               q_pop = 1'b1;
               idx_in = idx_c; tag_in = tag_c; last_in = q_data.is_last;
               st_in = sacl_pkg::BK_READ;
            end
         end
         sacl_pkg::BK_READ: st_in = sacl_pkg::BK_UPDATE;
         sacl_pkg::BK_UPDATE: begin
            wr_en = 1'b1;
            if (!hit) wr_line.tag = tag_ff;
            else wr_line.tag = rdata_ff[pick].tag;
            clk_in = clk_ff + 64'd1;
            if (hit) begin
               outc_in = sacl_pkg::OUTC_HIT;
               if (hit_ff != '1) hit_in = hit_ff + 1'b1;
            end else begin
               outc_in = empty ? sacl_pkg::OUTC_FILL : sacl_pkg::OUTC_EVICT;
               if (miss_ff != '1) miss_in = miss_ff + 1'b1;
               if (!empty && evc_ff != '1) evc_in = evc_ff + 1'b1;
            end
            wayo_in = sacl_pkg::WAYF_W'(pick);
            out_last_in = last_ff;
            out_v_in = 1'b1;
            st_in = sacl_pkg::BK_IDLE;
         end
         default: st_in = sacl_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sacl_pkg::BK_CLEAR; clr_ff <= '0; clk_ff <= 64'd1;
         hit_ff <= '0; miss_ff <= '0; evc_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; clk_ff <= clk_in;
         hit_ff <= hit_in; miss_ff <= miss_in; evc_ff <= evc_in; out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; tag_ff <= tag_in; last_ff <= last_in;
      outc_ff <= outc_in; wayo_ff <= wayo_in; out_last_ff <= out_last_in;
   end

   // Row memory: one row read, one row (or one way) written per cycle
   always_ff @(posedge clock) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         rdata_ff[w] <= mem[idx_ff][w];
         if (wr_en && (wr_all || wr_way == WAY_W'(w))) mem[wr_idx][w] <= wr_line;
      end
   end
endmodule

// ===== src/set_assoc_cache_lru_tag_model.sv =====
// Path from transfer in to result: queue, set read, update, registered result.
// The back end serves one access at a time, from set read to write back, and
// waits while a result is stalled; a modify gives two accesses.
// Reset: synchronous, active high; then a clearing pass sweeps all
// 2^MAX_SET_BITS sets (256 by default) before any access is served.
module set_assoc_cache_lru_tag_model #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   sacl_req_if.sink                          req,
   sacl_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   logic [3:0] set_bits_ff;
   logic [5:0] offset_bits_ff;
   logic [3:0] ways_ff;
   logic       q_valid, q_pop;
   sacl_pkg::access_type q_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= 4'd1; offset_bits_ff <= 6'd1; ways_ff <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            sacl_pkg::CSR_SET_BITS:    set_bits_ff    <= csr_wdata[3:0];
            sacl_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata;
            sacl_pkg::CSR_WAYS:        ways_ff        <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   sacl_front u_front (
      .clock, .reset, .req, .q_valid, .q_data, .q_pop
   );

   sacl_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
      .clock, .reset, .q_valid, .q_data, .q_pop,
      .set_bits(set_bits_ff), .offset_bits(offset_bits_ff), .ways_in_use(ways_ff),
      .rsp
   );
endmodule

// ===== src/sacl_checker.sv =====
`include "set_assoc_cache_lru_tag_model_assert.svh"
// Port-level checks on the result channel
module sacl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_outcome,
   input logic [31:0] rsp_hits,
   input logic [31:0] rsp_misses,
   input logic [31:0] rsp_evictions
);
   `SACL_ASSERT_IMP(a_outc_legal, clock, reset, rsp_valid,
      rsp_outcome <= sacl_pkg::OUTC_EVICT, "illegal outcome")
   `SACL_ASSERT_IMP(a_evict_le_miss, clock, reset, rsp_valid,
      rsp_evictions <= rsp_misses, "evictions exceed misses")
   `SACL_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hits), "result dropped while stalled")
   `SACL_ASSERT_IMP(a_hit_cnt, clock, reset,
      rsp_valid && rsp_outcome == sacl_pkg::OUTC_HIT,
      rsp_hits != 32'd0, "hit without hit count")
endmodule

bind set_assoc_cache_lru_tag_model sacl_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_outcome(rsp.outcome), .rsp_hits(rsp.hits_so_far),
   .rsp_misses(rsp.misses_so_far), .rsp_evictions(rsp.evictions_so_far)
);
